// ===== src/su2ss_pkg.sv =====
// Shared types, widths and arithmetic helpers for the SU(2) staple accumulator.
package su2ss_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DIMENSIONS = 4;

    localparam int LINK_W = FRAC_BITS + 2;
    localparam int SUM_W  = FRAC_BITS + 4;
    // Four products of up to 2^(2F) each, plus sign.
    localparam int PROD_W = 2 * FRAC_BITS + 4;
    localparam int ACC_W  = SUM_W + 1;

    localparam logic signed [LINK_W-1:0] ONE_LINK  = LINK_W'(64'd1 << FRAC_BITS);
    localparam logic signed [PROD_W-1:0] ONE_PROD  = PROD_W'(64'd1 << FRAC_BITS);
    localparam logic signed [PROD_W-1:0] HALF_PROD = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]  SUM_LIMIT =
        ACC_W'((64'd2 * 64'(DIMENSIONS - 1)) << FRAC_BITS);

    // Slot positions within a staple pair.
    localparam logic [2:0] SLOT_FWD_FIRST = 3'd0;
    localparam logic [2:0] SLOT_FWD_MID   = 3'd1;
    localparam logic [2:0] SLOT_FWD_END   = 3'd2;
    localparam logic [2:0] SLOT_BWD_FIRST = 3'd3;
    localparam logic [2:0] SLOT_BWD_MID   = 3'd4;
    localparam logic [2:0] SLOT_BWD_END   = 3'd5;

    typedef struct packed {
        logic signed [LINK_W-1:0] w;
        logic signed [LINK_W-1:0] x;
        logic signed [LINK_W-1:0] y;
        logic signed [LINK_W-1:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [SUM_W-1:0] w;
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } t_sum;

    function automatic logic signed [LINK_W-1:0] sat_link(input logic signed [LINK_W-1:0] v);
        logic signed [LINK_W-1:0] r;
        if (v > ONE_LINK) begin
            r = ONE_LINK;
        end else if (v < -ONE_LINK) begin
            r = -ONE_LINK;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [PROD_W-1:0] mul_ext(input logic signed [LINK_W-1:0] a,
                                                         input logic signed [LINK_W-1:0] b);
        logic signed [PROD_W-1:0] ea;
        logic signed [PROD_W-1:0] eb;
        ea = PROD_W'(a);
        eb = PROD_W'(b);
        return ea * eb;
    endfunction

    // Round to nearest with ties toward positive infinity, then saturate to +-1.0.
    // The arithmetic shift is a floor, which covers negative values as well.
    function automatic logic signed [LINK_W-1:0] round_sat(input logic signed [PROD_W-1:0] s);
        logic signed [PROD_W-1:0] t;
        logic signed [PROD_W-1:0] q;
        logic signed [PROD_W-1:0] c;
        t = s + HALF_PROD;
        q = t >>> FRAC_BITS;
        if (q > ONE_PROD) begin
            c = ONE_PROD;
        end else if (q < -ONE_PROD) begin
            c = -ONE_PROD;
        end else begin
            c = q;
        end
        return c[LINK_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] acc_add(input logic signed [SUM_W-1:0] acc,
                                                        input logic signed [LINK_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-1:0] c;
        s = ACC_W'(acc) + ACC_W'(v);
        if (s > SUM_LIMIT) begin
            c = SUM_LIMIT;
        end else if (s < -SUM_LIMIT) begin
            c = -SUM_LIMIT;
        end else begin
            c = s;
        end
        return c[SUM_W-1:0];
    endfunction

endpackage

// ===== src/su2_staple_sum.sv =====
// Top level: streams link quaternions, builds staple products and emits their sum.
//
//   Channel  Direction  Handshake                 Payload
//   in       into       i_in_valid / o_in_stall   i_link_w/x/y/z, i_slot, i_last
//   out      out of     o_out_valid / i_out_stall o_sum_w/x/y/z
//
// One link is accepted per cycle unless o_in_stall holds it off. A link is registered in
// the input register, where the quaternion multiply against the running product and the
// accumulator update run; a staple sum is then written to the output register once its
// last link advances out of the input register.
// Reset is synchronous and active low and clears the running product and accumulator.
// A stalled output only holds back a link flagged last; other links keep flowing.
module su2_staple_sum (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [su2ss_pkg::LINK_W-1:0]   i_link_w,
    input  logic signed [su2ss_pkg::LINK_W-1:0]   i_link_x,
    input  logic signed [su2ss_pkg::LINK_W-1:0]   i_link_y,
    input  logic signed [su2ss_pkg::LINK_W-1:0]   i_link_z,
    input  logic        [2:0]                     i_slot,
    input  logic                                  i_last,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [su2ss_pkg::SUM_W-1:0]    o_sum_w,
    output logic signed [su2ss_pkg::SUM_W-1:0]    o_sum_x,
    output logic signed [su2ss_pkg::SUM_W-1:0]    o_sum_y,
    output logic signed [su2ss_pkg::SUM_W-1:0]    o_sum_z
);
    import su2ss_pkg::*;

    logic        r_s1_valid;
    t_quat       r_s1_q;
    logic [2:0]  r_s1_slot;
    logic        r_s1_last;
    t_quat       r_prod;
    t_sum        r_acc;
    logic        r_out_valid;
    t_sum        r_out_sum;

    t_quat       n_s1_q;
    t_quat       n_prod;
    t_sum        n_acc;
    t_sum        n_sum;
    t_quat       mul_r;
    logic        advance;
    logic        in_take;
    logic        conj;

    su2ss_qmul u_qmul (
        .i_a (r_prod),
        .i_b (r_s1_q),
        .o_r (mul_r)
    );

    // A last link needs the output register free; others advance whenever present.
    assign advance    = r_s1_valid && (!r_s1_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Inputs are saturated to +-1.0, and the slots from FWD_MID to BWD_MID conjugated, before registering.
    always_comb begin
        conj = (i_slot == SLOT_FWD_MID) || (i_slot == SLOT_FWD_END)
            || (i_slot == SLOT_BWD_FIRST) || (i_slot == SLOT_BWD_MID);
        n_s1_q.w = sat_link(i_link_w);
        n_s1_q.x = sat_link(i_link_x);
        n_s1_q.y = sat_link(i_link_y);
        n_s1_q.z = sat_link(i_link_z);
        if (conj) begin
            n_s1_q.x = -n_s1_q.x;
            n_s1_q.y = -n_s1_q.y;
            n_s1_q.z = -n_s1_q.z;
        end
    end

    always_comb begin
        n_prod = r_prod;
        n_sum  = r_acc;
        case (r_s1_slot)
            SLOT_FWD_FIRST, SLOT_BWD_FIRST: begin
                n_prod = r_s1_q;
            end
            SLOT_FWD_MID, SLOT_BWD_MID: begin
                n_prod = mul_r;
            end
            SLOT_FWD_END, SLOT_BWD_END: begin
                n_prod  = mul_r;
                n_sum.w = acc_add(r_acc.w, mul_r.w);
                n_sum.x = acc_add(r_acc.x, mul_r.x);
                n_sum.y = acc_add(r_acc.y, mul_r.y);
                n_sum.z = acc_add(r_acc.z, mul_r.z);
            end
            default: begin
                n_prod = r_prod;
            end
        endcase
        n_acc = r_s1_last ? '0 : n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prod      <= '0;
            r_acc       <= '0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_prod <= n_prod;
                r_acc  <= n_acc;
            end
            if (advance && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_q    <= n_s1_q;
            r_s1_slot <= i_slot;
            r_s1_last <= i_last;
        end
        if (advance && r_s1_last) begin
            r_out_sum <= n_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sum_w     = r_out_sum.w;
    assign o_sum_x     = r_out_sum.x;
    assign o_sum_y     = r_out_sum.y;
    assign o_sum_z     = r_out_sum.z;

endmodule

// ===== src/su2ss_qmul.sv =====
// Combinational SU(2) quaternion product with rounding and saturation per component.
module su2ss_qmul (
    input  su2ss_pkg::t_quat i_a,
    input  su2ss_pkg::t_quat i_b,
    output su2ss_pkg::t_quat o_r
);
    import su2ss_pkg::*;

    logic signed [PROD_W-1:0] s_w;
    logic signed [PROD_W-1:0] s_x;
    logic signed [PROD_W-1:0] s_y;
    logic signed [PROD_W-1:0] s_z;

    // scalar = a0*b0 - a.b, vector = a0*b + b0*a - a x b
    always_comb begin
        s_w = mul_ext(i_a.w, i_b.w)
            - (mul_ext(i_a.x, i_b.x) + mul_ext(i_a.y, i_b.y) + mul_ext(i_a.z, i_b.z));
        s_x = mul_ext(i_a.w, i_b.x) + mul_ext(i_b.w, i_a.x)
            - (mul_ext(i_a.y, i_b.z) - mul_ext(i_a.z, i_b.y));
        s_y = mul_ext(i_a.w, i_b.y) + mul_ext(i_b.w, i_a.y)
            - (mul_ext(i_a.z, i_b.x) - mul_ext(i_a.x, i_b.z));
        s_z = mul_ext(i_a.w, i_b.z) + mul_ext(i_b.w, i_a.z)
            - (mul_ext(i_a.x, i_b.y) - mul_ext(i_a.y, i_b.x));
        o_r.w = round_sat(s_w);
        o_r.x = round_sat(s_x);
        o_r.y = round_sat(s_y);
        o_r.z = round_sat(s_z);
    end

endmodule

// ===== tb/su2_staple_sum_tb.sv =====
// Self-checking testbench for su2_staple_sum: streamed links against a staple-sum predictor.
module su2_staple_sum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import su2ss_pkg::*;

    localparam logic [2:0] SLOT_SPARE_LO = 3'd6;
    localparam logic [2:0] SLOT_SPARE_HI = 3'd7;
    localparam int N_ITEMS      = 1750;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam logic signed [LINK_W-1:0] L_ONE  = 18'sd65536;
    localparam logic signed [LINK_W-1:0] L_MONE = -18'sd65536;
    localparam logic signed [LINK_W-1:0] L_MAX  = 18'sd131071;
    localparam logic signed [LINK_W-1:0] L_MIN  = -18'sd131072;

    // Predicts staple sums from accepted links and checks emitted sums in order.
    class staple_scoreboard;
        longint run_q[4];
        longint acc_q[4];
        t_sum   sums_due[$];
        int     errors;
        int     mismatches;

        function new();
            for (int i = 0; i < 4; i++) begin
                run_q[i] = 0;
                acc_q[i] = 0;
            end
            errors = 0;
            mismatches = 0;
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // Q2.32 down to Q1.16, nearest with ties up; the arithmetic shift is a floor.
        function longint round_q(longint v);
            return clamp((v + 64'sd32768) >>> FRAC_BITS, 64'sd65536);
        endfunction

        function void note_link(logic signed [LINK_W-1:0] w, logic signed [LINK_W-1:0] x,
                                logic signed [LINK_W-1:0] y, logic signed [LINK_W-1:0] z,
                                logic [2:0] slot, logic last);
            longint b[4];
            longint a[4];
            longint s[4];
            t_sum   sum;
            b[0] = clamp(longint'(w), 64'sd65536);
            b[1] = clamp(longint'(x), 64'sd65536);
            b[2] = clamp(longint'(y), 64'sd65536);
            b[3] = clamp(longint'(z), 64'sd65536);
            if (slot >= SLOT_FWD_MID && slot <= SLOT_BWD_MID) begin
                for (int i = 1; i < 4; i++) b[i] = -b[i];
            end
            if (slot == SLOT_FWD_FIRST || slot == SLOT_BWD_FIRST) begin
                run_q = b;
            end else if (slot >= SLOT_FWD_MID && slot <= SLOT_BWD_END) begin
                a = run_q;
                s[0] = a[0] * b[0] - (a[1] * b[1] + a[2] * b[2] + a[3] * b[3]);
                s[1] = a[0] * b[1] + b[0] * a[1] - (a[2] * b[3] - a[3] * b[2]);
                s[2] = a[0] * b[2] + b[0] * a[2] - (a[3] * b[1] - a[1] * b[3]);
                s[3] = a[0] * b[3] + b[0] * a[3] - (a[1] * b[2] - a[2] * b[1]);
                for (int i = 0; i < 4; i++) run_q[i] = round_q(s[i]);
                if (slot == SLOT_FWD_END || slot == SLOT_BWD_END) begin
                    for (int i = 0; i < 4; i++) begin
                        acc_q[i] = clamp(acc_q[i] + run_q[i], 64'sd393216);
                    end
                end
            end
            if (last) begin
                sum.w = SUM_W'(acc_q[0]);
                sum.x = SUM_W'(acc_q[1]);
                sum.y = SUM_W'(acc_q[2]);
                sum.z = SUM_W'(acc_q[3]);
                sums_due.push_back(sum);
                for (int i = 0; i < 4; i++) acc_q[i] = 0;
            end
        endfunction

        function void check_sum(t_sum got);
            t_sum want;
            if (sums_due.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("ERROR: unexpected sum w=%0d x=%0d y=%0d z=%0d",
                             got.w, got.x, got.y, got.z);
                end
                mismatches++;
                errors++;
                return;
            end
            want = sums_due.pop_front();
            if (got.w !== want.w || got.x !== want.x || got.y !== want.y ||
                got.z !== want.z) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("ERROR: sum expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                             want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
                end
                mismatches++;
                errors++;
            end
        endfunction

        function int pending();
            return sums_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_stall;
    logic signed [LINK_W-1:0] link_w = '0;
    logic signed [LINK_W-1:0] link_x = '0;
    logic signed [LINK_W-1:0] link_y = '0;
    logic signed [LINK_W-1:0] link_z = '0;
    logic [2:0] slot = '0;
    logic last = 1'b0;
    logic o_out_valid;
    logic out_stall = 1'b0;
    logic signed [SUM_W-1:0] o_sum_w;
    logic signed [SUM_W-1:0] o_sum_x;
    logic signed [SUM_W-1:0] o_sum_y;
    logic signed [SUM_W-1:0] o_sum_z;

    staple_scoreboard sb;
    bit quiet = 1'b0;
    int links_sent = 0;
    int idle_cycles = 0;

    su2_staple_sum u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_link_w    (link_w),
        .i_link_x    (link_x),
        .i_link_y    (link_y),
        .i_link_z    (link_z),
        .i_slot      (slot),
        .i_last      (last),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_sum_w     (o_sum_w),
        .o_sum_x     (o_sum_x),
        .o_sum_y     (o_sum_y),
        .o_sum_z     (o_sum_z)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Transaction monitor and progress watchdog; reads pre-edge values.
    always @(posedge i_clk) begin
        t_sum got;
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                got.w = o_sum_w;
                got.x = o_sum_x;
                got.y = o_sum_y;
                got.z = o_sum_z;
                sb.check_sum(got);
            end
            if (in_valid && !o_in_stall) begin
                sb.note_link(link_w, link_x, link_y, link_z, slot, last);
            end
            if ((o_out_valid && !out_stall) || (in_valid && !o_in_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    // Receiver: holds off each sum for a random number of cycles.
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_link(input logic signed [LINK_W-1:0] w, input logic signed [LINK_W-1:0] x,
                             input logic signed [LINK_W-1:0] y, input logic signed [LINK_W-1:0] z,
                             input logic [2:0] s, input logic l);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        link_w <= w;
        link_x <= x;
        link_y <= y;
        link_z <= z;
        slot <= s;
        last <= l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (s < SLOT_SPARE_LO) links_sent++;
    endtask

    function automatic logic signed [LINK_W-1:0] rand_comp();
        logic signed [LINK_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = ($urandom_range(0, 1) == 0) ? L_ONE : L_MONE;
            1: v = LINK_W'($urandom);
            2, 3: v = LINK_W'($signed($urandom_range(0, 32768)) - 16384);
            default: v = LINK_W'($signed($urandom_range(0, 131072)) - 65536);
        endcase
        return v;
    endfunction

    task automatic send_rand_link(input logic [2:0] s, input logic l);
        send_link(rand_comp(), rand_comp(), rand_comp(), rand_comp(), s, l);
    endtask

    initial begin
        int pairs;
        int drop_slot;
        int next_phase;
        sb = new();
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // One full staple pair, mostly of unit quaternions, some given beyond full scale.
        send_link(L_MAX, '0, '0, '0, SLOT_FWD_FIRST, 1'b0);
        send_link('0, L_ONE, '0, '0, SLOT_FWD_MID, 1'b0);
        send_link('0, '0, L_ONE, '0, SLOT_FWD_END, 1'b0);
        send_link('0, '0, '0, L_MONE, SLOT_BWD_FIRST, 1'b0);
        send_link(L_MONE, '0, '0, '0, SLOT_BWD_MID, 1'b0);
        send_link('0, L_MIN, L_ONE, L_MAX, SLOT_BWD_END, 1'b1);
        // Repeated end slots drive the accumulator into positive saturation.
        send_link(L_MAX, '0, '0, '0, SLOT_FWD_FIRST, 1'b0);
        for (int i = 0; i < 7; i++) send_link(L_ONE, '0, '0, '0, SLOT_BWD_END, i == 6);
        // And into negative saturation.
        send_link(L_MIN, '0, '0, '0, SLOT_FWD_FIRST, 1'b0);
        for (int i = 0; i < 7; i++) send_link(L_ONE, '0, '0, '0, SLOT_BWD_END, i == 6);
        // Spare slots change nothing but still close a sum.
        send_link(L_MAX, L_MIN, L_MAX, L_MIN, SLOT_SPARE_LO, 1'b1);
        send_link(-18'sd1, -18'sd1, -18'sd1, -18'sd1, SLOT_SPARE_HI, 1'b1);
        // An end slot out of order works on the product kept from before.
        send_link(L_ONE, L_MAX, L_MIN, '0, SLOT_FWD_END, 1'b1);

        next_phase = links_sent + 250;
        while (links_sent < N_ITEMS) begin
            if (links_sent >= next_phase) begin
                quiet = ($urandom_range(0, 3) == 0);
                next_phase = links_sent + 250;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_rand_link(3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
            end else begin
                pairs = $urandom_range(1, 3);
                // Now and then one slot of the group is left out.
                drop_slot = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6 * pairs - 1) : -1;
                for (int p = 0; p < pairs; p++) begin
                    for (int s = SLOT_FWD_FIRST; s <= SLOT_BWD_END; s++) begin
                        if (p * 6 + s != drop_slot) begin
                            send_rand_link(3'(s), (p == pairs - 1) && (s == SLOT_BWD_END));
                        end
                    end
                end
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
